FILE: src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication sampled on the rising clock edge, off while reset is asserted.
`define CDD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Same, with the consequence checked in the next cycle.
`define CDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/cdd_pkg.sv
package cdd_pkg;

	localparam int COUNT_BITS_DEF = 10;
	// Fixed input field bits besides count: command, day, month, year.
	localparam int IN_FIXED_W = 28;
	localparam int OUT_FIELD_W = 25;
	localparam int OUT_DATA_W = 32;
	// Widest unit multiplier (1000) needs this many bits.
	localparam int MULT_W = 10;

	typedef enum logic [2:0] {
		CMD_DAY        = 3'd0,
		CMD_WEEK       = 3'd1,
		CMD_MONTH      = 3'd2,
		CMD_YEAR       = 3'd3,
		CMD_DECADE     = 3'd4,
		CMD_CENTURY    = 3'd5,
		CMD_MILLENNIUM = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_DAY   = 2'd0,
		MODE_MONTH = 2'd1,
		MODE_YEAR  = 2'd2
	} mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic left_zero;
	} dp_status_t;

	localparam logic [4:0] MONTH_DAYS [13] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Gregorian leap test on a two's complement year. Divisibility by 25 is
	// found by folding base-256 digits (256 mod 25 = 6); a negative year adds
	// 14 because 65536 mod 25 = 11.
	function automatic logic leap_year(input logic [15:0] y);
		logic [10:0] fold1;
		logic [8:0]  fold2;
		logic [8:0]  v;
		logic        div25;
		fold1 = 11'(y[15:8]) * 11'd6 + 11'(y[7:0]);
		fold2 = 9'(fold1[10:8]) * 9'd6 + 9'(fold1[7:0]);
		v = fold2 + (y[15] ? 9'd14 : 9'd0);
		div25 = 1'b0;
		for (int k = 0; k <= 12; k++) begin
			if (v == 9'(25 * k))
				div25 = 1'b1;
		end
		return div25 ? (y[3:0] == 4'd0) : (y[1:0] == 2'd0);
	endfunction

	// Length of a month; months outside January to December have length 0.
	function automatic logic [4:0] month_length(input logic [15:0] y, input logic [3:0] m);
		logic [4:0] len;
		if (m == 4'd0 || m > 4'd12)
			len = 5'd0;
		else if (m == 4'd2)
			len = leap_year(y) ? 5'd29 : 5'd28;
		else
			len = MONTH_DAYS[m];
		return len;
	endfunction

endpackage

FILE: src/cdd_ctrl.sv
module cdd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  cdd_pkg::dp_status_t   stat,
	output cdd_pkg::ctl_cmd_t     ctl
);

	cdd_pkg::state_t state_q, state_nx;
	logic            out_valid_q, out_valid_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= out_valid_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			cdd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_nx = cdd_pkg::ST_RUN;
				end
			end
			cdd_pkg::ST_RUN: begin
				if (stat.left_zero) begin
					// Finished: move into the output register once it is free.
					if (!out_valid_q || out_ready) begin
						ctl.emit = 1'b1;
						state_nx = cdd_pkg::ST_IDLE;
					end
				end else begin
					ctl.step = 1'b1;
				end
			end
			default: state_nx = cdd_pkg::ST_IDLE;
		endcase
		if (ctl.emit)
			out_valid_nx = 1'b1;
		else if (out_ready)
			out_valid_nx = 1'b0;
		else
			out_valid_nx = out_valid_q;
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/cdd_datapath.sv
module cdd_datapath #(
	parameter int COUNT_BITS = cdd_pkg::COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  cdd_pkg::ctl_cmd_t       ctl,
	output cdd_pkg::dp_status_t     stat,
	input  logic [2:0]              command,
	input  logic [COUNT_BITS-1:0]   count,
	input  logic [4:0]              day_in,
	input  logic [3:0]              month_in,
	input  logic signed [15:0]      year_in,
	output logic [4:0]              day_out,
	output logic [3:0]              month_out,
	output logic signed [15:0]      year_out
);

	localparam int N_W = COUNT_BITS + cdd_pkg::MULT_W;

	logic [4:0]                day_q, day_nx, day_out_q;
	logic [3:0]                month_q, month_nx, month_out_q;
	logic [15:0]               year_q, year_nx, year_out_q;
	logic [N_W-1:0]            left_q, left_nx, prod;
	cdd_pkg::mode_t            mode_q, load_mode;
	logic [cdd_pkg::MULT_W-1:0] mult;

	logic [15:0] year_dec;
	logic [3:0]  bk_month;
	logic [15:0] bk_year;
	logic [4:0]  bk_len;

	// Unit multiplier and step kind chosen by the command.
	always_comb begin
		case (command)
			cdd_pkg::CMD_DAY: begin
				mult = 10'd1;    load_mode = cdd_pkg::MODE_DAY;
			end
			cdd_pkg::CMD_WEEK: begin
				mult = 10'd7;    load_mode = cdd_pkg::MODE_DAY;
			end
			cdd_pkg::CMD_MONTH: begin
				mult = 10'd1;    load_mode = cdd_pkg::MODE_MONTH;
			end
			cdd_pkg::CMD_YEAR: begin
				mult = 10'd1;    load_mode = cdd_pkg::MODE_YEAR;
			end
			cdd_pkg::CMD_DECADE: begin
				mult = 10'd10;   load_mode = cdd_pkg::MODE_YEAR;
			end
			cdd_pkg::CMD_CENTURY: begin
				mult = 10'd100;  load_mode = cdd_pkg::MODE_YEAR;
			end
			cdd_pkg::CMD_MILLENNIUM: begin
				mult = 10'd1000; load_mode = cdd_pkg::MODE_YEAR;
			end
			default: begin
				mult = 10'd0;    load_mode = cdd_pkg::MODE_DAY;
			end
		endcase
	end

	assign prod     = N_W'(count) * N_W'(mult);
	assign year_dec = year_q - 16'd1;
	assign bk_month = (month_q == 4'd1) ? 4'd12 : month_q - 4'd1;
	assign bk_year  = (month_q == 4'd1) ? year_dec : year_q;
	assign bk_len   = cdd_pkg::month_length(bk_year, bk_month);

	always_comb begin
		day_nx   = day_q;
		month_nx = month_q;
		year_nx  = year_q;
		left_nx  = left_q - N_W'(1);
		case (mode_q)
			cdd_pkg::MODE_DAY: begin
				if (day_q > 5'd1) begin
					day_nx = day_q - 5'd1;
				end else begin
					month_nx = bk_month;
					year_nx  = bk_year;
					day_nx   = (month_q == 4'd1) ? 5'd31 : bk_len;
				end
			end
			cdd_pkg::MODE_MONTH: begin
				month_nx = bk_month;
				year_nx  = bk_year;
				day_nx   = (day_q > bk_len) ? bk_len : day_q;
			end
			cdd_pkg::MODE_YEAR: begin
				if (!(month_q == 4'd2 && day_q == 5'd29)) begin
					year_nx = year_q - 16'(left_q);
					left_nx = '0;
				end else begin
					if (!cdd_pkg::leap_year(year_dec))
						day_nx = 5'd28;
					year_nx = year_dec;
				end
			end
			default: left_nx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			day_q   <= day_in;
			month_q <= month_in;
			year_q  <= $unsigned(year_in);
			left_q  <= prod;
			mode_q  <= load_mode;
		end else if (ctl.step) begin
			day_q   <= day_nx;
			month_q <= month_nx;
			year_q  <= year_nx;
			left_q  <= left_nx;
		end
		if (ctl.emit) begin
			day_out_q   <= day_q;
			month_out_q <= month_q;
			year_out_q  <= year_q;
		end
	end

	assign stat.left_zero = (left_q == '0);
	assign day_out        = day_out_q;
	assign month_out      = month_out_q;
	assign year_out       = $signed(year_out_q);

endmodule

FILE: src/calendar_date_decrement.sv
// Step loop: one step per cycle; the step counter is loaded with count times the
// unit multiplier (7 for week, 1 for day and month), and year units need one subtract
// after at most two single-year steps for 29 February.
// Throughput: one word at a time; the next word can be taken as soon as the result
// is in the output register, even while the sink still holds it off.
// Reset: arst_n clears the controller and output valid asynchronously; data is not reset.
`include "assert_macros.svh"

// Gregorian date decrement. A word carries a date, a unit and a count; the
// result is the date moved back by count units. The controller loads the
// datapath, runs its step loop until the remaining-step counter is zero and
// then copies the working date into an output register, so the next input
// word can be taken while a result still waits for the sink.
module calendar_date_decrement #(
	parameter int COUNT_BITS = cdd_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// Input word. s_tdata from bit 0: command[3], count[COUNT_BITS], day_in[5],
	// month_in[4], year_in[16], zero padding to whole bytes.
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((cdd_pkg::IN_FIXED_W + COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// Result word. m_tdata from bit 0: day_out[5], month_out[4], year_out[16],
	// zero padding to 32 bits.
	output logic m_tvalid,
	input  logic m_tready,
	output logic [cdd_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int DAY_LSB   = 3 + COUNT_BITS;
	localparam int MONTH_LSB = DAY_LSB + 5;
	localparam int YEAR_LSB  = MONTH_LSB + 4;

	cdd_pkg::ctl_cmd_t   ctl;
	cdd_pkg::dp_status_t stat;

	logic [4:0]         day_out;
	logic [3:0]         month_out;
	logic signed [15:0] year_out;

	// The controller sequences load, step and emit.
	cdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// The datapath holds the working date, the step counter and the result register.
	cdd_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.ctl       (ctl),
		.stat      (stat),
		.command   (s_tdata[2:0]),
		.count     (s_tdata[3 +: COUNT_BITS]),
		.day_in    (s_tdata[DAY_LSB +: 5]),
		.month_in  (s_tdata[MONTH_LSB +: 4]),
		.year_in   ($signed(s_tdata[YEAR_LSB +: 16])),
		.day_out   (day_out),
		.month_out (month_out),
		.year_out  (year_out)
	);

	assign m_tdata = {{(cdd_pkg::OUT_DATA_W - cdd_pkg::OUT_FIELD_W){1'b0}},
		$unsigned(year_out), month_out, day_out};

	// Only one word is in work at a time.
	`CDD_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken while a word is in work")
	// A result appears only once the step counter has run out.
	`CDD_ASSERT_IMPL(a_emit_when_done, clk, arst_n, $rose(m_tvalid), $past(stat.left_zero), "result written before the steps were done")
	// The loop never steps past zero remaining steps.
	`CDD_ASSERT_IMPL(a_no_extra_step, clk, arst_n, ctl.step, !stat.left_zero, "step issued with no steps left")

endmodule
